### hdl/rrt_pkg.sv
// Package for the relay response time tester.
// Phase type, tick limits and default constants. No dependencies.
package rrt_pkg;

    localparam int SAMPLE_COUNT = 10;
    localparam int SETTLE_W     = 16;
    localparam int TICK_W       = 24;
    localparam int NUM_W        = 7;
    localparam int AVG_W        = 31;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd500;
    localparam logic [TICK_W-1:0]   TICK_MAX     = 24'hFFFFFF;
    localparam int                  SCALE        = 100;

    typedef enum logic [1:0] {
        PH_SETTLING  = 2'd0,
        PH_MEASURING = 2'd1,
        PH_DONE      = 2'd2
    } phase_t;

endpackage

### hdl/rrt_if.sv
// Channel interfaces for the relay response time tester.
// Depends on rrt_pkg for field widths.
interface rrt_tick_if;
    logic valid;
    logic ready;
    logic contact_rise;

    modport source (output valid, output contact_rise, input ready);
    modport sink   (input valid, input contact_rise, output ready);
endinterface

interface rrt_result_if;
    logic                          valid;
    logic                          ready;
    logic                          relay_drive;
    logic                          sample_valid;
    logic [rrt_pkg::NUM_W-1:0]     sample_number;
    logic [rrt_pkg::TICK_W-1:0]    response_ticks;
    logic                          done_res;
    logic [rrt_pkg::AVG_W-1:0]     average_hundredths;

    modport source (output valid, output relay_drive, output sample_valid,
                    output sample_number, output response_ticks, output done_res,
                    output average_hundredths, input ready);
    modport sink   (input valid, input relay_drive, input sample_valid,
                    input sample_number, input response_ticks, input done_res,
                    input average_hundredths, output ready);
endinterface

### hdl/relay_response_time_tester.sv
// Relay response time tester, top level.
// Depends on rrt_pkg and the channel interfaces in rrt_if.sv.
//
// Channel   Dir  Payload
// tick      in   contact_rise
// result    out  relay_drive, sample_valid, sample_number, response_ticks,
//                done_res, average_hundredths
// cfg       in   cfg_wr_en, cfg_wr_data (settle_ticks)
//
// One tick transfer per cycle unless the result stalls; each result is registered.
// The mean is kept as a running quotient and remainder of the scaled sum, updated
// by a constant step and one compare-subtract on each unsaturated measuring tick.
// A tick is taken while the output register is empty or being emptied.
// Reset: settling phase, counters cleared, settle_ticks back to 500.
module relay_response_time_tester #(
    parameter int SAMPLE_COUNT = rrt_pkg::SAMPLE_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rrt_tick_if.sink                        tick,
    rrt_result_if.source                    result,
    input  logic                            cfg_wr_en,
    input  logic [rrt_pkg::SETTLE_W-1:0]    cfg_wr_data
);

    localparam int TW = rrt_pkg::TICK_W;
    localparam int NW = rrt_pkg::NUM_W;
    localparam int AW = rrt_pkg::AVG_W;
    localparam int REM_W = (SAMPLE_COUNT > 1) ? $clog2(2 * SAMPLE_COUNT) : 1;
    localparam int Q_STEP = rrt_pkg::SCALE / SAMPLE_COUNT;
    localparam int R_STEP = rrt_pkg::SCALE % SAMPLE_COUNT;
    localparam int R_INIT = SAMPLE_COUNT / 2;
    localparam logic [NW-1:0]    COUNT_N  = NW'(SAMPLE_COUNT);
    localparam logic [REM_W-1:0] DIV_N    = REM_W'(SAMPLE_COUNT);
    localparam logic [REM_W-1:0] R_STEP_V = REM_W'(R_STEP);
    localparam logic [AW-1:0]    Q_STEP_V = AW'(Q_STEP);

    rrt_pkg::phase_t phase_reg, phase_next;
    logic [rrt_pkg::SETTLE_W-1:0] settle_reg;
    logic [TW-1:0]    elapsed_reg, elapsed_next, elapsed_inc;
    logic [NW-1:0]    samples_reg, samples_next, samples_inc;
    logic [AW-1:0]    quot_reg, quot_next;
    logic [REM_W-1:0] rem_reg, rem_next, rem_sum;
    logic             unsat;
    logic             accept;

    logic             out_valid_reg;
    logic             relay_reg, relay_next;
    logic             svalid_reg, svalid_next;
    logic [NW-1:0]    snum_reg, snum_next;
    logic [TW-1:0]    resp_reg, resp_next;
    logic             done_reg, done_next;
    logic [AW-1:0]    avg_reg, avg_next;

    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    assign unsat       = (elapsed_reg != rrt_pkg::TICK_MAX);
    assign elapsed_inc = unsat ? elapsed_reg + TW'(1) : elapsed_reg;
    assign samples_inc = samples_reg + NW'(1);

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            rrt_pkg::PH_SETTLING:
            begin
                if (elapsed_inc >= TW'(settle_reg))
                    phase_next = rrt_pkg::PH_MEASURING;
            end
            rrt_pkg::PH_MEASURING:
            begin
                if (tick.contact_rise)
                    phase_next = (samples_inc >= COUNT_N) ? rrt_pkg::PH_DONE
                                                          : rrt_pkg::PH_SETTLING;
            end
            default:
                phase_next = phase_reg;
        endcase
    end

    // counters, running mean and result
    always_comb
    begin
        elapsed_next = elapsed_reg;
        samples_next = samples_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        rem_sum      = rem_reg + R_STEP_V;
        relay_next   = 1'b0;
        svalid_next  = 1'b0;
        snum_next    = '0;
        resp_next    = '0;
        case (phase_reg)
            rrt_pkg::PH_SETTLING:
            begin
                elapsed_next = elapsed_inc;
                if (phase_next == rrt_pkg::PH_MEASURING)
                begin
                    elapsed_next = '0;
                    relay_next   = 1'b1;
                end
            end
            rrt_pkg::PH_MEASURING:
            begin
                elapsed_next = elapsed_inc;
                relay_next   = 1'b1;
                if (unsat)
                begin
                    // sum*100 + N/2 held as quotient and remainder of N
                    if (rem_sum >= DIV_N)
                    begin
                        rem_next  = rem_sum - DIV_N;
                        quot_next = quot_reg + Q_STEP_V + AW'(1);
                    end
                    else
                    begin
                        rem_next  = rem_sum;
                        quot_next = quot_reg + Q_STEP_V;
                    end
                end
                if (tick.contact_rise)
                begin
                    resp_next    = elapsed_inc;
                    samples_next = samples_inc;
                    svalid_next  = 1'b1;
                    snum_next    = samples_inc;
                    relay_next   = 1'b0;
                    elapsed_next = '0;
                end
            end
            default:
            begin
                elapsed_next = elapsed_reg;
            end
        endcase
        done_next = (phase_next == rrt_pkg::PH_DONE);
        avg_next  = done_next ? quot_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rrt_pkg::PH_SETTLING;
            settle_reg    <= rrt_pkg::SETTLE_RESET;
            elapsed_reg   <= '0;
            samples_reg   <= '0;
            quot_reg      <= '0;
            rem_reg       <= REM_W'(R_INIT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                settle_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                samples_reg <= samples_next;
                quot_reg    <= quot_next;
                rem_reg     <= rem_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            relay_reg  <= relay_next;
            svalid_reg <= svalid_next;
            snum_reg   <= snum_next;
            resp_reg   <= resp_next;
            done_reg   <= done_next;
            avg_reg    <= avg_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.relay_drive        = relay_reg;
    assign result.sample_valid       = svalid_reg;
    assign result.sample_number      = snum_reg;
    assign result.response_ticks     = resp_reg;
    assign result.done_res           = done_reg;
    assign result.average_hundredths = avg_reg;

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rrt_pkg::PH_DONE |=> phase_reg == rrt_pkg::PH_DONE)
        else $error("done phase left before reset");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < DIV_N || SAMPLE_COUNT == 1)
        else $error("mean remainder out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        samples_reg <= COUNT_N)
        else $error("sample count beyond limit");

    a_sample_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.sample_valid |->
            result.response_ticks != '0 && result.sample_number != '0
            && !result.relay_drive)
        else $error("completed sample with zero count or relay on");

endmodule
